FILE: hdl/lgs_pkg.sv
// Shared types and constants for the life generation stencil core.
// Holds the channel payload structs, the B3/S23 rule table and register indexes.
// No dependencies; every other file but lgs_ram refers to it by scoped names.
`default_nettype none

package lgs_pkg;

  // Field widths fixed by the interface.
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int COL_OUT_W   = 10;
  localparam int ROW_OUT_W   = 10;
  localparam int COUNT_W     = 21;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

  // Size registers come out of reset at 1024.
  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

  // Live counter saturates at all ones.
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Rule lookup: index is neighbor count plus nine times the center bit.
  localparam int                RULE_DEPTH  = 19;
  localparam int                RULE_IDX_W  = 5;
  localparam logic [RULE_IDX_W-1:0] SELF_WEIGHT = 5'd9;
  localparam logic RULE_TABLE [RULE_DEPTH] = '{
    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
  };

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic cell_alive;
    logic start_frame;
  } in_item_t;

  typedef struct packed {
    logic                 next_alive;
    logic [COL_OUT_W-1:0] out_col;
    logic [ROW_OUT_W-1:0] out_row;
    logic [COUNT_W-1:0]   live_count;
    logic                 frame_done;
  } out_item_t;

  // One classified result waiting for the back part.
  typedef struct packed {
    logic                 next_alive;
    logic [COL_OUT_W-1:0] out_col;
    logic [ROW_OUT_W-1:0] out_row;
    logic                 frame_done;
    logic                 clear_first;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

FILE: hdl/lgs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Parameterized in width and depth; no dependencies.
`default_nettype none

module lgs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lgs_front.sv
// Front part: accepts cells, tracks the raster position, runs the line stores
// and the 3x3 window, and pushes classified results into the queue.
// Depends on lgs_pkg and lgs_ram.
`default_nettype none

module lgs_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [lgs_pkg::CFG_W-1:0] grid_width,
  input  wire logic [lgs_pkg::CFG_W-1:0] grid_height,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire lgs_pkg::in_item_t         in_data,
  output logic                           push_valid,
  output lgs_pkg::q_entry_t              push_data,
  input  wire lgs_pkg::q_status_t        q_status
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WCMP = ($clog2(MAX_WIDTH + 1) > lgs_pkg::CFG_W) ?
                        $clog2(MAX_WIDTH + 1) : lgs_pkg::CFG_W;
  localparam int HCMP = ($clog2(MAX_HEIGHT + 1) > lgs_pkg::CFG_W) ?
                        $clog2(MAX_HEIGHT + 1) : lgs_pkg::CFG_W;
  localparam int CWX  = (CW > lgs_pkg::COL_OUT_W) ? CW : lgs_pkg::COL_OUT_W;
  localparam int RWX  = (RW > lgs_pkg::ROW_OUT_W) ? RW : lgs_pkg::ROW_OUT_W;

  // Item held between the line store read and the window update.
  typedef struct packed {
    logic          alive;
    logic          start;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    logic          emit;
    logic          frame_end;
    logic          fwd;
    logic [1:0]    fwd_bits;
  } stage_t;

  logic            s1_valid_r, s1_valid_nxt;
  stage_t          s1_r;
  logic [CW-1:0]   col_pos_r, col_pos_nxt;
  logic [RW-1:0]   row_pos_r, row_pos_nxt;
  logic [8:0]      win_r, win_nxt;
  logic            clr_pend_r, clr_pend_nxt;

  logic            accept, s1_move;
  logic [WCMP-1:0] w_ext, w_use, col_ext;
  logic [HCMP-1:0] h_ext, h_use, row_ext;
  logic [CW-1:0]   col_cur;
  logic [RW-1:0]   row_cur;
  logic            row_end, frame_end, emit;
  logic [1:0]      ram_rdata, col_bits;
  logic [1:0]      wr_bits;
  logic [3:0]      nbrs;
  logic [lgs_pkg::RULE_IDX_W-1:0] rule_idx;
  logic [CWX-1:0]  col_m1;
  logic [RWX-1:0]  row_m1;

  // Handshake: a new cell enters when no item is held or the held item leaves.
  assign s1_move  = s1_valid_r && (!s1_r.emit || !q_status.full);
  assign in_ready = !s1_valid_r || s1_move;
  assign accept   = in_valid && in_ready;

  // Clamp the sizes and classify the incoming cell's position.
  always_comb begin
    w_ext = WCMP'(grid_width);
    h_ext = HCMP'(grid_height);
    if (w_ext < WCMP'(3)) begin
      w_use = WCMP'(3);
    end else if (w_ext > WCMP'(MAX_WIDTH)) begin
      w_use = WCMP'(MAX_WIDTH);
    end else begin
      w_use = w_ext;
    end
    if (h_ext < HCMP'(3)) begin
      h_use = HCMP'(3);
    end else if (h_ext > HCMP'(MAX_HEIGHT)) begin
      h_use = HCMP'(MAX_HEIGHT);
    end else begin
      h_use = h_ext;
    end

    col_cur   = in_data.start_frame ? '0 : col_pos_r;
    row_cur   = in_data.start_frame ? '0 : row_pos_r;
    col_ext   = WCMP'(col_cur);
    row_ext   = HCMP'(row_cur);
    row_end   = col_ext >= (w_use - WCMP'(1));
    frame_end = row_end && (row_ext >= (h_use - HCMP'(1)));
    emit      = (col_ext >= WCMP'(2)) && (row_ext >= HCMP'(2)) &&
                (col_ext < w_use) && (row_ext < h_use);

    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    if (accept) begin
      if (frame_end) begin
        col_pos_nxt = '0;
        row_pos_nxt = '0;
      end else if (row_end) begin
        col_pos_nxt = '0;
        row_pos_nxt = row_cur + RW'(1);
      end else begin
        col_pos_nxt = col_cur + CW'(1);
        row_pos_nxt = row_cur;
      end
    end
  end

  // Line stores: bit 1 holds row r-2, bit 0 holds row r-1.
  lgs_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_r.col),
    .wdata (wr_bits),
    .re    (accept),
    .raddr (col_cur),
    .rdata (ram_rdata)
  );

  // Window shift and rule lookup for the held item.
  always_comb begin
    col_bits = s1_r.fwd ? s1_r.fwd_bits : ram_rdata;
    wr_bits  = {col_bits[0], s1_r.alive};
    win_nxt  = {win_r[5:0], col_bits, s1_r.alive};
    nbrs     = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        nbrs = nbrs + {3'b000, win_nxt[i]};
      end
    end
    rule_idx = {1'b0, nbrs} + (win_nxt[4] ? lgs_pkg::SELF_WEIGHT : '0);
    col_m1   = CWX'(s1_r.col) - CWX'(1);
    row_m1   = RWX'(s1_r.row) - RWX'(1);

    push_valid             = s1_valid_r && s1_r.emit && !q_status.full;
    push_data.next_alive   = lgs_pkg::RULE_TABLE[rule_idx];
    push_data.out_col      = col_m1[lgs_pkg::COL_OUT_W-1:0];
    push_data.out_row      = row_m1[lgs_pkg::ROW_OUT_W-1:0];
    push_data.frame_done   = s1_r.frame_end;
    push_data.clear_first  = clr_pend_r || s1_r.start;

    // A frame boundary seen on a cell without a result clears the count later.
    clr_pend_nxt = clr_pend_r;
    if (s1_move) begin
      if (s1_r.emit) begin
        clr_pend_nxt = 1'b0;
      end else if (s1_r.start || s1_r.frame_end) begin
        clr_pend_nxt = 1'b1;
      end
    end

    s1_valid_nxt = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      col_pos_r  <= '0;
      row_pos_r  <= '0;
      win_r      <= '0;
      clr_pend_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      col_pos_r  <= col_pos_nxt;
      row_pos_r  <= row_pos_nxt;
      clr_pend_r <= clr_pend_nxt;
      if (s1_move) begin
        win_r <= win_nxt;
      end
    end
  end

  // Held item; the write of the leaving item is forwarded on an address match.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.alive     <= in_data.cell_alive;
      s1_r.start     <= in_data.start_frame;
      s1_r.col       <= col_cur;
      s1_r.row       <= row_cur;
      s1_r.emit      <= emit;
      s1_r.frame_end <= frame_end;
      s1_r.fwd       <= s1_move && (s1_r.col == col_cur);
      s1_r.fwd_bits  <= wr_bits;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lgs_queue.sv
// Short register queue between the front and back parts.
// Depends on lgs_pkg for the entry type and depth.
`default_nettype none

module lgs_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire lgs_pkg::q_entry_t  push_data,
  input  wire logic               pop,
  output lgs_pkg::q_entry_t       head,
  output lgs_pkg::q_status_t      status
);

  lgs_pkg::q_entry_t               entries [lgs_pkg::QUEUE_DEPTH];
  logic [lgs_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [lgs_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [lgs_pkg::QCNT_W-1:0]      count_r, count_nxt;

  // Pointer and fill bookkeeping.
  always_comb begin
    status.full  = count_r == lgs_pkg::QCNT_W'(lgs_pkg::QUEUE_DEPTH);
    status.empty = count_r == '0;
    head         = entries[rd_ptr_r];
    wr_ptr_nxt   = push ? wr_ptr_r + lgs_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt   = pop  ? rd_ptr_r + lgs_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt    = count_r + lgs_pkg::QCNT_W'(push) - lgs_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lgs_back.sv
// Back part: takes classified results from the queue, keeps the frame's
// live count and drives the output register. Depends on lgs_pkg.
`default_nettype none

module lgs_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lgs_pkg::q_entry_t  head,
  input  wire lgs_pkg::q_status_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lgs_pkg::out_item_t      out_data
);

  logic                          out_valid_r, out_valid_nxt;
  lgs_pkg::out_item_t            out_data_r;
  logic [lgs_pkg::COUNT_W-1:0]   total_r, total_nxt;
  logic [lgs_pkg::COUNT_W-1:0]   base, count;

  // Take an entry whenever the output register is free or being emptied.
  assign pop       = !q_status.empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Running count with saturation; frame boundaries clear it.
  always_comb begin
    base  = head.clear_first ? '0 : total_r;
    count = base + lgs_pkg::COUNT_W'(head.next_alive && (base != lgs_pkg::COUNT_MAX));
    total_nxt = total_r;
    if (pop) begin
      total_nxt = head.frame_done ? '0 : count;
    end
    out_valid_nxt = pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r.next_alive <= head.next_alive;
      out_data_r.out_col    <= head.out_col;
      out_data_r.out_row    <= head.out_row;
      out_data_r.live_count <= count;
      out_data_r.frame_done <= head.frame_done;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/life_generation_stencil_core.sv
// Game of Life (B3/S23) next-generation stencil. Cells of one generation enter
// one per clock in raster order while the queue has room, a rate set by the
// line store RAM taking one read and one write each cycle. Once the cell that
// completes its 3x3 window is accepted, each interior cell's next state passes
// the queue and the output register and leaves with its column, row, the
// frame's running live count and an end-of-frame mark. Border cells produce
// no result. A queue of four results between the window logic and the output
// register absorbs output stalls. The user must write sizes through the cfg
// port while idle; the block does not check it. The line stores need no
// clearing after reset. Depends on lgs_pkg, lgs_front, lgs_queue and lgs_back.
`default_nettype none

module life_generation_stencil_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire lgs_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output lgs_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lgs_pkg::CFG_W-1:0]     cfg_data
);

  logic [lgs_pkg::CFG_W-1:0] grid_width_r, grid_width_nxt;
  logic [lgs_pkg::CFG_W-1:0] grid_height_r, grid_height_nxt;
  logic                      push_valid, pop;
  lgs_pkg::q_entry_t         push_data, head;
  lgs_pkg::q_status_t        q_status;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    if (cfg_valid) begin
      case (cfg_index)
        lgs_pkg::CFG_GRID_WIDTH:  grid_width_nxt  = cfg_data;
        lgs_pkg::CFG_GRID_HEIGHT: grid_height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= lgs_pkg::CFG_SIZE_RESET;
      grid_height_r <= lgs_pkg::CFG_SIZE_RESET;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
    end
  end

  lgs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .grid_width  (grid_width_r),
    .grid_height (grid_height_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .push_valid  (push_valid),
    .push_data   (push_data),
    .q_status    (q_status)
  );

  lgs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  lgs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: hdl/lgs_checker.sv
// Port-level checks for the stencil core, attached by a bind statement.
// Depends on lgs_pkg and on the core's port list.
`default_nettype none

module lgs_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire lgs_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire lgs_pkg::out_item_t out_data
);

  logic done_seen_r;

  // Remember whether the last result transaction ended a frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_seen_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      done_seen_r <= out_data.frame_done;
    end
  end

  // A waiting input transaction keeps its valid and its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while waiting");

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No result is offered in the cycle after a reset.
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result offered right after reset");

  // A live cell is always included in the count it reports.
  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.next_alive |-> out_data.live_count != '0)
    else $error("live result with zero count");

  // The result that follows a frame end carries a count that starts over.
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_seen_r |->
      out_data.live_count == lgs_pkg::COUNT_W'(out_data.next_alive))
    else $error("count did not start over after a frame end");

endmodule

bind life_generation_stencil_core lgs_checker u_lgs_checker (.*);

`default_nettype wire
